[rtl/llrs_pkg.sv]
// Shared types and constants for the life-like automaton row step block.
// Used by llrs_cell and life_like_automaton_row_step_top; no dependencies.
package llrs_pkg;

  localparam int ROW_BITS   = 64;
  localparam int MASK_BITS  = 9;
  localparam int WIDTH_BITS = 7;
  localparam int IDX_BITS   = 2;
  localparam int CNT_BITS   = 4;

  localparam logic [IDX_BITS-1:0] REG_BIRTH   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SURVIVE = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_WIDTH   = 2'd2;

  localparam logic [MASK_BITS-1:0]  BIRTH_RESET   = 9'd8;
  localparam logic [MASK_BITS-1:0]  SURVIVE_RESET = 9'd12;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 7'd64;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                final_row;
  } row_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_row;
    logic                board_done;
  } res_t;

  // Masked bits one cell shares with its left and right neighbors.
  typedef struct packed {
    logic up;
    logic mid;
    logic row;
  } nbr_t;

  typedef struct packed {
    logic [MASK_BITS-1:0] birth;
    logic [MASK_BITS-1:0] survive;
  } rule_t;

  // Row-level control broadcast to every cell.
  typedef struct packed {
    logic load;
    logic shift;
    logic last;
  } ctrl_t;

endpackage

[rtl/life_like_automaton_row_step_top.sv]
// Top level of the life-like automaton row step: a chain of column cells and a
// two-entry result queue. Depends on llrs_pkg and llrs_cell.
//
// Usage:
//   Rows of the board enter on the row channel (row_valid/row_ready/row), top row
//   first, one row per request; final_row marks the bottom row. Results leave on
//   the res channel (res_valid/res_ready/res). The first row of a board yields no
//   result; each later row yields the next generation of the row above it, and
//   the bottom row yields two results, the second with board_done set. A
//   one-row board yields a single result with board_done set.
//   Rule and width registers are written on the cfg channel (cfg_index 0 birth
//   mask, 1 survival mask, 2 row width); cfg_ready is always high. Write them
//   only while the block is idle.
// Timing:
//   A result is registered: it shows on res in the cycle after the row that
//   completes it is accepted. The cells evaluate a whole row combinationally, so
//   one row per cycle is sustained while res_ready stays high; a bottom row
//   holds off the next row while its two results drain through the queue.
//   A new row is taken when the queue is empty or its single entry leaves in
//   the same cycle, so a stalled receiver holds off at most two results.
// Reset:
//   rst clears the stored rows, the queue and the registers to B3/S23, width 64.
module life_like_automaton_row_step_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               row_valid,
  output logic                               row_ready,
  input  llrs_pkg::row_t                     row,
  output logic                               res_valid,
  input  logic                               res_ready,
  output llrs_pkg::res_t                     res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [llrs_pkg::IDX_BITS-1:0]      cfg_index,
  input  logic [llrs_pkg::MASK_BITS-1:0]     cfg_data
);

  localparam int RB = llrs_pkg::ROW_BITS;
  localparam int WB = llrs_pkg::WIDTH_BITS;

  // Configuration registers.
  llrs_pkg::rule_t      rule;
  logic [WB-1:0]        row_width;
  logic [WB-1:0]        eff_width;

  // Row state and queue.
  logic                 middle_valid;
  llrs_pkg::res_t       q0;
  llrs_pkg::res_t       q1;
  logic [1:0]           cnt;
  logic [1:0]           cnt_next;
  llrs_pkg::res_t       q0_next;
  llrs_pkg::res_t       q1_next;

  logic                 accept;
  logic                 pop;
  llrs_pkg::ctrl_t      ctrl;
  logic [1:0]           push_n;

  logic [RB-1:0]        col_on;
  logic [RB-1:0]        gen_a;
  logic [RB-1:0]        gen_b;
  llrs_pkg::nbr_t       lane [RB];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule.birth   <= llrs_pkg::BIRTH_RESET;
      rule.survive <= llrs_pkg::SURVIVE_RESET;
      row_width    <= llrs_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        llrs_pkg::REG_BIRTH:   rule.birth   <= cfg_data;
        llrs_pkg::REG_SURVIVE: rule.survive <= cfg_data;
        llrs_pkg::REG_WIDTH:   row_width    <= cfg_data[WB-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the width to the number of cells built.
  assign eff_width = (row_width > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : row_width;

  assign pop       = res_valid & res_ready;
  assign row_ready = (cnt == 2'd0) || ((cnt == 2'd1) && res_ready);
  assign accept    = row_valid & row_ready;

  assign ctrl.load  = accept;
  assign ctrl.shift = middle_valid;
  assign ctrl.last  = row.final_row;

  // Chain of column cells; columns past MAX_WIDTH stay dead.
  for (genvar k = 0; k < RB; k++) begin : g_col
    if (k < MAX_WIDTH) begin : g_cell
      llrs_pkg::nbr_t lnb;
      llrs_pkg::nbr_t rnb;
      assign col_on[k] = (WB'(k) < eff_width);
      if (k == 0) begin : g_ledge
        assign lnb = '0;
      end else begin : g_lnb
        assign lnb = lane[k-1];
      end
      if (k == MAX_WIDTH - 1) begin : g_redge
        assign rnb = '0;
      end else begin : g_rnb
        assign rnb = lane[k+1];
      end
      llrs_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .col_on  (col_on[k]),
        .rule    (rule),
        .ctrl    (ctrl),
        .row_bit (row.row_cells[k]),
        .left    (lnb),
        .right   (rnb),
        .own     (lane[k]),
        .gen_a   (gen_a[k]),
        .gen_b   (gen_b[k])
      );
    end else begin : g_dead
      assign col_on[k] = 1'b0;
      assign lane[k]   = '0;
      assign gen_a[k]  = 1'b0;
      assign gen_b[k]  = 1'b0;
    end
  end

  // Pending row present: emit A, and B too on the bottom row. No pending row:
  // only a bottom row emits, as B with board_done.
  always_comb begin
    if (middle_valid) begin
      push_n = row.final_row ? 2'd2 : 2'd1;
    end else begin
      push_n = row.final_row ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    q0_next  = q0;
    q1_next  = q1;
    cnt_next = cnt;
    if (accept) begin
      if (middle_valid) begin
        q0_next.next_row   = gen_a;
        q0_next.board_done = 1'b0;
      end else begin
        q0_next.next_row   = gen_b;
        q0_next.board_done = 1'b1;
      end
      q1_next.next_row   = gen_b;
      q1_next.board_done = 1'b1;
      cnt_next           = push_n;
    end else if (pop) begin
      q0_next  = q1;
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= 2'd0;
      middle_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        middle_valid <= ~row.final_row;
      end
    end
  end

  // Queue payload: no reset needed.
  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign res_valid = (cnt != 2'd0);
  assign res       = q0;

endmodule

[rtl/llrs_cell.sv]
// One column cell: holds the upper and middle bits of its column and counts neighbors.
// Depends on llrs_pkg for the neighbor, rule and control structs.
module llrs_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           col_on,
  input  llrs_pkg::rule_t rule,
  input  llrs_pkg::ctrl_t ctrl,
  input  logic           row_bit,
  input  llrs_pkg::nbr_t left,
  input  llrs_pkg::nbr_t right,
  output llrs_pkg::nbr_t own,
  output logic           gen_a,
  output logic           gen_b
);

  logic upper;
  logic middle;
  logic [llrs_pkg::CNT_BITS-1:0]  cnt_a;
  logic [llrs_pkg::CNT_BITS-1:0]  cnt_b;
  logic [llrs_pkg::MASK_BITS-1:0] mask_a;
  logic [llrs_pkg::MASK_BITS-1:0] mask_b;

  assign own.up  = upper & col_on;
  assign own.mid = middle & col_on;
  assign own.row = row_bit & col_on;

  // A: pending row between upper and incoming row. B: incoming row with dead row below.
  assign cnt_a = {3'b000, left.up} + {3'b000, own.up} + {3'b000, right.up}
               + {3'b000, left.mid} + {3'b000, right.mid}
               + {3'b000, left.row} + {3'b000, own.row} + {3'b000, right.row};
  assign cnt_b = {3'b000, left.mid} + {3'b000, own.mid} + {3'b000, right.mid}
               + {3'b000, left.row} + {3'b000, right.row};

  assign mask_a = own.mid ? rule.survive : rule.birth;
  assign mask_b = own.row ? rule.survive : rule.birth;
  assign gen_a  = col_on & mask_a[cnt_a];
  assign gen_b  = col_on & mask_b[cnt_b];

  always_ff @(posedge clk) begin
    if (rst) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else if (ctrl.load) begin
      upper  <= ctrl.shift & ~ctrl.last & own.mid;
      middle <= ~ctrl.last & own.row;
    end
  end

endmodule
